@@ hw/rtl/urad_pkg.sv @@
// ----------------------------------------------------------------------------
// urad_pkg
// Shared types and constants of the aggregated receive-transfer deframer.
// ----------------------------------------------------------------------------
package urad_pkg;

	// Segment framing
	localparam int HEADER_BYTES       = 4;
	localparam int TRAILER_BYTES      = 4;
	localparam int MIN_SEGMENT_BYTES  = 36;
	localparam int MAX_TRANSFER_BYTES = 16384;
	localparam logic [1:0] LEN_ALIGN_MASK = 2'h3;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int XLEN_W   = 15;
	localparam int PLEN_W   = 16;
	localparam int COUNT_W  = 16;
	localparam int WORD_W   = 32;
	localparam int SEGIDX_W = 12;
	localparam int STATUS_W = 3;

	// Packed stream widths
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 56;
	localparam int M_TUSER_W = 2;

	localparam logic [SEGIDX_W-1:0] SEGIDX_MAX = '1;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER,
		PH_DROP
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		STOP_NONE,
		STOP_TOO_SHORT,
		STOP_ZERO_LEN,
		STOP_OVERRUN,
		STOP_MISALIGNED
	} stop_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   payload_byte;
		logic                payload_valid;
		logic                segment_done;
		logic [WORD_W-1:0]   trailer_word;
		logic [SEGIDX_W-1:0] segment_index;
		stop_t               stop_status;
	} result_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              start_of_transfer;
		logic [XLEN_W-1:0] transfer_len;
	} item_t;

endpackage

@@ hw/rtl/usb_rx_aggregate_deframer.sv @@
// ----------------------------------------------------------------------------
// usb_rx_aggregate_deframer
// Splits a received bulk transfer into aggregated segments, one byte an item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one transfer byte per item. tuser marks the first byte of
//   a transfer, which also carries the transfer length in tdata.
//   Master stream: one item per payload byte, one per finished trailer
//   (trailer word, segment index, any stop status), and one when parsing
//   stops otherwise; bytes that produce none of these give no item.
//   cfg_we/cfg_wdata write the enable bit; write it only while idle.
// Data path:
//   An accepted item waits in the input register; one pass of next-state
//   logic advances the parse state once per byte and loads any result into
//   the result register, shown on the master side from then on. One item is
//   taken every cycle unless back-pressure holds the input register.
// Reset:
//   arst_n clears the enable bit, the parse state (idle) and both valid flags.
// Back-pressure:
//   When m_tready is low with a result held, the input register holds its
//   byte and s_tready drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module usb_rx_aggregate_deframer (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	// slave stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [7:0] data_byte, [22:8] transfer_len, [23] zero
	input  logic [urad_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] start_of_transfer
	input  logic [urad_pkg::S_TUSER_W-1:0] s_tuser,
	// master stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] payload_byte, [39:8] trailer_word, [51:40] segment_index,
	// [54:52] stop_status, [55] zero
	output logic [urad_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] payload_valid, [1] segment_done
	output logic [urad_pkg::M_TUSER_W-1:0] m_tuser
);
	import urad_pkg::*;

	logic    enable_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    out_free;
	logic    fire;
	logic    has_result;
	result_t result;

	// hold the enable bit; only sampled on the first byte of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_wdata;
		end
	end

	// input register: advance whenever the held byte is being consumed
	assign fire     = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte         <= s_tdata[BYTE_W-1:0];
			item_s1.transfer_len      <= s_tdata[BYTE_W+XLEN_W-1:BYTE_W];
			item_s1.start_of_transfer <= s_tuser[0];
		end
	end

	urad_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.enable     (enable_q),
		.fire       (fire),
		.item       (item_s1),
		.result     (result),
		.has_result (has_result)
	);

	// drop bytes that produce no result; register the rest
	urad_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (fire && has_result),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

@@ hw/rtl/urad_parser.sv @@
// ----------------------------------------------------------------------------
// urad_parser
// Segment parse state and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module urad_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enable,
	input  logic             fire,
	input  urad_pkg::item_t  item,
	output urad_pkg::result_t result,
	output logic             has_result
);
	import urad_pkg::*;

	phase_t              phase_q, phase_n;
	logic [COUNT_W-1:0]  count_q, count_n;
	logic [XLEN_W-1:0]   remaining_q, remaining_n;
	logic [PLEN_W-1:0]   plen_q, plen_n;
	logic [BYTE_W-1:0]   len_low_q, len_low_n;
	logic [WORD_W-1:0]   trailer_q, trailer_n;
	logic [SEGIDX_W-1:0] seen_q, seen_n;

	logic [XLEN_W-1:0]   tl_clamped;
	logic [XLEN_W-1:0]   rem_dec;
	logic [COUNT_W:0]    count_inc;
	logic [PLEN_W-1:0]   plen_new;
	logic [XLEN_W+1:0]   seg_left;
	logic [PLEN_W:0]     seg_need;
	logic [WORD_W-1:0]   trailer_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			remaining_q <= '0;
			plen_q      <= '0;
			len_low_q   <= '0;
			trailer_q   <= '0;
			seen_q      <= '0;
		end else if (fire) begin
			phase_q     <= phase_n;
			count_q     <= count_n;
			remaining_q <= remaining_n;
			plen_q      <= plen_n;
			len_low_q   <= len_low_n;
			trailer_q   <= trailer_n;
			seen_q      <= seen_n;
		end
	end

	always_comb begin
		if ({2'b00, item.transfer_len} > (XLEN_W+2)'(MAX_TRANSFER_BYTES)) begin
			tl_clamped = XLEN_W'(MAX_TRANSFER_BYTES);
		end else begin
			tl_clamped = item.transfer_len;
		end
	end

	always_comb begin
		phase_n     = phase_q;
		count_n     = count_q;
		remaining_n = remaining_q;
		plen_n      = plen_q;
		len_low_n   = len_low_q;
		trailer_n   = trailer_q;
		seen_n      = seen_q;
		result      = '0;
		has_result  = 1'b0;
		rem_dec     = '0;
		count_inc   = '0;
		plen_new    = '0;
		seg_left    = '0;
		seg_need    = '0;
		trailer_upd = '0;

		// a new transfer restarts everything
		if (item.start_of_transfer) begin
			remaining_n = tl_clamped;
			seen_n      = '0;
			count_n     = '0;
			trailer_n   = '0;
			plen_n      = '0;
			len_low_n   = '0;
			if (!enable) begin
				phase_n = PH_DROP;
			end else if ({2'b00, tl_clamped} < (XLEN_W+2)'(MIN_SEGMENT_BYTES)) begin
				phase_n            = PH_DROP;
				result.stop_status = STOP_TOO_SHORT;
				has_result         = 1'b1;
			end else begin
				phase_n = PH_HEADER;
			end
		end

		if (!has_result && (phase_n == PH_HEADER || phase_n == PH_PAYLOAD ||
				phase_n == PH_TRAILER)) begin
			rem_dec     = (remaining_n != '0) ? remaining_n - XLEN_W'(1) : remaining_n;
			count_inc   = {1'b0, count_n} + (COUNT_W+1)'(1);
			plen_new    = {item.data_byte, len_low_n};
			seg_left    = {2'b00, remaining_n} + (XLEN_W+2)'(1);
			seg_need    = {1'b0, plen_new} + (PLEN_W+1)'(HEADER_BYTES + TRAILER_BYTES);
			trailer_upd = trailer_n;
			remaining_n = rem_dec;

			case (phase_n)
				PH_HEADER: begin
					if (count_n == COUNT_W'(0)) begin
						len_low_n = item.data_byte;
					end else if (count_n == COUNT_W'(1)) begin
						plen_n = plen_new;
						if (plen_new == '0) begin
							result.stop_status = STOP_ZERO_LEN;
							has_result         = 1'b1;
						end else if (seg_need > seg_left) begin
							result.stop_status = STOP_OVERRUN;
							has_result         = 1'b1;
						end else if ((plen_new[1:0] & LEN_ALIGN_MASK) != 2'b00) begin
							result.stop_status = STOP_MISALIGNED;
							has_result         = 1'b1;
						end
					end
					if (has_result) begin
						phase_n = PH_DROP;
					end else if (count_inc >= (COUNT_W+1)'(HEADER_BYTES)) begin
						phase_n = PH_PAYLOAD;
						count_n = '0;
					end else begin
						count_n = count_inc[COUNT_W-1:0];
					end
				end
				PH_PAYLOAD: begin
					result.payload_byte  = item.data_byte;
					result.payload_valid = 1'b1;
					has_result           = 1'b1;
					if (count_inc >= {1'b0, plen_n}) begin
						phase_n   = PH_TRAILER;
						count_n   = '0;
						trailer_n = '0;
					end else begin
						count_n = count_inc[COUNT_W-1:0];
					end
				end
				PH_TRAILER: begin
					// little-endian assembly of the info word
					case (count_n[1:0])
						2'd0:    trailer_upd[7:0]   = trailer_n[7:0]   | item.data_byte;
						2'd1:    trailer_upd[15:8]  = trailer_n[15:8]  | item.data_byte;
						2'd2:    trailer_upd[23:16] = trailer_n[23:16] | item.data_byte;
						default: trailer_upd[31:24] = trailer_n[31:24] | item.data_byte;
					endcase
					trailer_n = trailer_upd;
					if (count_inc >= (COUNT_W+1)'(TRAILER_BYTES)) begin
						result.segment_done  = 1'b1;
						result.trailer_word  = trailer_upd;
						result.segment_index = seen_n;
						has_result           = 1'b1;
						if (seen_n != SEGIDX_MAX) begin
							seen_n = seen_n + SEGIDX_W'(1);
						end
						count_n = '0;
						if ({2'b00, rem_dec} < (XLEN_W+2)'(MIN_SEGMENT_BYTES)) begin
							result.stop_status = STOP_TOO_SHORT;
							phase_n            = PH_DROP;
						end else begin
							phase_n = PH_HEADER;
						end
					end else begin
						count_n = count_inc[COUNT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/urad_out_reg.sv @@
// ----------------------------------------------------------------------------
// urad_out_reg
// Result register feeding the master stream; frees itself as it is taken.
// ----------------------------------------------------------------------------
module urad_out_reg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              load,
	input  urad_pkg::result_t                 result,
	output logic                              free,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [urad_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic [urad_pkg::M_TUSER_W-1:0]    m_tuser
);
	import urad_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, res_q.stop_status, res_q.segment_index,
		res_q.trailer_word, res_q.payload_byte};
	assign m_tuser  = {res_q.segment_done, res_q.payload_valid};

endmodule

@@ verif/usb_rx_aggregate_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// usb_rx_aggregate_deframer_tb
// Self-checking bench for the aggregated receive-transfer deframer: feeds
// whole transfers (well-formed segment chains, malformed headers, short,
// oversized and cut-off transfers, stray bytes) byte by byte, predicts every
// master-side item in a scoreboard and compares each one field by field.
// ----------------------------------------------------------------------------
module usb_rx_aggregate_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import urad_pkg::*;

	// Scoreboard: tracks the parse state of the deframer and holds the
	// results still owed by the block, oldest first.
	class deframe_scoreboard;
		bit                  enabled;
		phase_t              ph;
		int unsigned         cnt;
		int unsigned         left;
		int unsigned         plen;
		logic [7:0]          len_lo;
		logic [31:0]         tword;
		logic [SEGIDX_W-1:0] segs;
		result_t             owed[$];
		int unsigned         failures;

		function new();
			enabled  = 1'b0;
			ph       = PH_IDLE;
			cnt      = 0;
			left     = 0;
			plen     = 0;
			len_lo   = '0;
			tword    = '0;
			segs     = '0;
			failures = 0;
		endfunction

		function void set_enable(bit v);
			enabled = v;
		endfunction

		function void owe(logic [7:0] b, logic pv, logic done, logic [31:0] w,
				logic [SEGIDX_W-1:0] idx, stop_t st);
			result_t r;
			r.payload_byte  = b;
			r.payload_valid = pv;
			r.segment_done  = done;
			r.trailer_word  = w;
			r.segment_index = idx;
			r.stop_status   = st;
			owed.push_back(r);
		endfunction

		// Advance the parse state by one accepted byte.
		function void note_item(logic [7:0] b, logic sot, logic [XLEN_W-1:0] tl);
			int unsigned         left_prev;
			int unsigned         seg_left;
			stop_t               st;
			logic [SEGIDX_W-1:0] idx;
			if (sot) begin
				left = (tl > MAX_TRANSFER_BYTES) ? MAX_TRANSFER_BYTES : tl;
				segs   = '0;
				cnt    = 0;
				tword  = '0;
				plen   = 0;
				len_lo = '0;
				if (!enabled) begin
					ph = PH_DROP;
					return;
				end
				if (left < MIN_SEGMENT_BYTES) begin
					ph = PH_DROP;
					owe('0, 1'b0, 1'b0, '0, '0, STOP_TOO_SHORT);
					return;
				end
				ph = PH_HEADER;
			end
			if (ph != PH_HEADER && ph != PH_PAYLOAD && ph != PH_TRAILER)
				return;
			left_prev = left;
			if (left > 0)
				left--;
			case (ph)
				PH_HEADER: begin
					if (cnt == 0) begin
						len_lo = b;
					end else if (cnt == 1) begin
						// bytes left when the segment began, header included
						seg_left = left_prev + 1;
						plen     = {b, len_lo};
						st       = STOP_NONE;
						if (plen == 0)
							st = STOP_ZERO_LEN;
						else if (plen + HEADER_BYTES + TRAILER_BYTES > seg_left)
							st = STOP_OVERRUN;
						else if ((plen & LEN_ALIGN_MASK) != 0)
							st = STOP_MISALIGNED;
						if (st != STOP_NONE) begin
							ph = PH_DROP;
							owe('0, 1'b0, 1'b0, '0, '0, st);
							return;
						end
					end
					cnt++;
					if (cnt >= HEADER_BYTES) begin
						ph  = PH_PAYLOAD;
						cnt = 0;
					end
				end
				PH_PAYLOAD: begin
					owe(b, 1'b1, 1'b0, '0, '0, STOP_NONE);
					cnt++;
					if (cnt >= plen) begin
						ph    = PH_TRAILER;
						cnt   = 0;
						tword = '0;
					end
				end
				default: begin
					tword = tword | (32'(b) << (8 * (cnt & 3)));
					cnt++;
					if (cnt >= TRAILER_BYTES) begin
						idx = segs;
						if (segs < SEGIDX_MAX)
							segs++;
						cnt = 0;
						if (left < MIN_SEGMENT_BYTES) begin
							st = STOP_TOO_SHORT;
							ph = PH_DROP;
						end else begin
							st = STOP_NONE;
							ph = PH_HEADER;
						end
						owe('0, 1'b0, 1'b1, tword, idx, st);
					end
				end
			endcase
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] d, logic [M_TUSER_W-1:0] u);
			result_t got;
			result_t want;
			bit      bad;
			got.payload_byte  = d[7:0];
			got.trailer_word  = d[39:8];
			got.segment_index = d[51:40];
			got.stop_status   = stop_t'(d[54:52]);
			got.payload_valid = u[0];
			got.segment_done  = u[1];
			if (owed.size() == 0) begin
				if (failures < 10)
					$display("%0t: unexpected item byte=%h pv=%b done=%b word=%h idx=%0d st=%0d",
						$realtime, got.payload_byte, got.payload_valid, got.segment_done,
						got.trailer_word, got.segment_index, got.stop_status);
				failures++;
				return;
			end
			want = owed.pop_front();
			bad = (got.payload_byte !== want.payload_byte)
				|| (got.payload_valid !== want.payload_valid)
				|| (got.segment_done !== want.segment_done)
				|| (got.trailer_word !== want.trailer_word)
				|| (got.segment_index !== want.segment_index)
				|| (got.stop_status !== want.stop_status);
			if (bad) begin
				if (failures < 10) begin
					$display("%0t: mismatch expected byte=%h pv=%b done=%b word=%h idx=%0d st=%0d",
						$realtime, want.payload_byte, want.payload_valid, want.segment_done,
						want.trailer_word, want.segment_index, want.stop_status);
					$display("%0t:          actual   byte=%h pv=%b done=%b word=%h idx=%0d st=%0d",
						$realtime, got.payload_byte, got.payload_valid, got.segment_done,
						got.trailer_word, got.segment_index, got.stop_status);
				end
				failures++;
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic                 cfg_wdata = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [S_TUSER_W-1:0] s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	deframe_scoreboard sb = new();

	// Bytes of the transfer being assembled; the first one carries the start mark.
	logic [7:0] xfer_bytes[$];

	bit src_idle_on   = 1'b1;
	bit sink_idle_on  = 1'b1;
	bit long_hold_req = 1'b0;
	int hold_left     = 0;

	usb_rx_aggregate_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: check every accepted result and drive m_tready. A long
	// hold-off, when asked for, is counted here so the sender keeps offering
	// items while the block fills up.
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_result(m_tdata, m_tuser);
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left     = 299;
			m_tready <= 1'b0;
		end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
			hold_left = $urandom_range(0, 13);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_item(input logic [7:0] b, input logic sot, input logic [XLEN_W-1:0] tl);
		if (src_idle_on && $urandom_range(0, 9) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, tl, b};
		s_tuser  <= sot;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_item(b, sot, tl);
	endtask

	// Send the assembled transfer; the length field of later bytes is noise.
	task automatic send_transfer(input logic [XLEN_W-1:0] tl);
		foreach (xfer_bytes[i])
			send_item(xfer_bytes[i], i == 0, (i == 0) ? tl : XLEN_W'($urandom));
	endtask

	// Wait until nothing is owed, then give the input register time to empty.
	task automatic drain(input int settle);
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_enable(input bit v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_enable(v);
	endtask

	task automatic push_random(input int n);
		repeat (n) xfer_bytes.push_back(8'($urandom));
	endtask

	// Header with length, two ignored bytes, payload and trailer word.
	task automatic push_segment(input int unsigned plen);
		xfer_bytes.push_back(plen[7:0]);
		xfer_bytes.push_back(plen[15:8]);
		push_random(2 + plen + TRAILER_BYTES);
	endtask

	// A header that stops the parse: zero, misaligned or overrunning length.
	task automatic push_bad_header();
		logic [15:0] v;
		case ($urandom_range(0, 2))
			0: v = '0;
			1: v = 16'(4 * $urandom_range(0, 8) + $urandom_range(1, 3));
			default: v = 16'($urandom_range(16377, 65535));
		endcase
		xfer_bytes.push_back(v[7:0]);
		xfer_bytes.push_back(v[15:8]);
	endtask

	// Assemble one random transfer: mostly chains of good segments with a
	// random tail, the rest noise, bad headers, short or oversized lengths.
	task automatic build_transfer(output logic [XLEN_W-1:0] tl);
		int          kind;
		int          tail;
		int unsigned size;
		xfer_bytes.delete();
		kind = $urandom_range(0, 19);
		if (kind <= 13 || kind == 19) begin
			repeat ($urandom_range(1, 4)) push_segment(4 * $urandom_range(1, 12));
			tail = $urandom_range(0, 9);
			case (tail)
				0, 1, 2, 3: push_random($urandom_range(0, 35));
				4, 5: begin
					push_bad_header();
					push_random($urandom_range(34, 42));
				end
				9: push_random($urandom_range(36, 60));
				default: ;
			endcase
			size = xfer_bytes.size();
			tl   = XLEN_W'(size);
			if (tail == 6)
				tl = XLEN_W'(size + $urandom_range(1, 60));
			else if (tail == 7 && size > 20)
				tl = XLEN_W'(size - $urandom_range(1, 20));
			else if (tail == 8)
				repeat ($urandom_range(1, size - 1)) void'(xfer_bytes.pop_back());
			if (kind == 19)
				tl = XLEN_W'($urandom_range(MAX_TRANSFER_BYTES + 1, 32767));
		end else if (kind <= 15) begin
			push_random($urandom_range(1, 20));
			tl = XLEN_W'($urandom);
		end else if (kind <= 17) begin
			push_bad_header();
			push_random($urandom_range(34, 40));
			tl = XLEN_W'(xfer_bytes.size());
		end else begin
			tl = XLEN_W'($urandom_range(0, MIN_SEGMENT_BYTES - 1));
			push_random($urandom_range(1, 8));
		end
	endtask

	task automatic run_random(input int target);
		int               sent;
		logic [XLEN_W-1:0] tl;
		sent = 0;
		while (sent < target) begin
			// stray bytes between transfers do not count toward the target
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 4)) send_item(8'($urandom), 1'b0, XLEN_W'($urandom));
			build_transfer(tl);
			send_transfer(tl);
			sent += xfer_bytes.size();
		end
	endtask

	initial begin
		logic [XLEN_W-1:0] tl;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Disabled: the whole transfer and a stray byte are dropped silently.
		write_enable(1'b0);
		xfer_bytes = '{8'h04, 8'h00};
		send_transfer(15'd40);
		send_item(8'hFF, 1'b0, '1);
		drain(4);
		write_enable(1'b1);

		// Receiver holds off for a long stretch right at the start of this phase.
		long_hold_req = 1'b1;

		// One good segment; the header's extra bytes are ignored and the
		// transfer runs short after the trailer.
		xfer_bytes = '{8'h04, 8'h00, 8'hAA, 8'h55, 8'h00, 8'hFF, 8'h80, 8'h7F,
			8'h01, 8'h02, 8'h03, 8'hFF};
		send_transfer(15'd36);
		// too short at the very first byte
		xfer_bytes = '{8'h5A};
		send_transfer(15'd0);
		// zero length
		xfer_bytes = '{8'h00, 8'h00};
		send_transfer(15'd40);
		// segment overruns the transfer
		xfer_bytes = '{8'hFC, 8'h7F};
		send_transfer(15'd40);
		// length not a multiple of four
		xfer_bytes = '{8'h05, 8'h00};
		send_transfer(15'd40);
		// oversized length, then abandoned mid-header by the next start
		xfer_bytes = '{8'h08, 8'h00, 8'hC3};
		send_transfer(15'h7FFF);

		run_random(300);
		drain(4);

		// Disabled again: random transfers all vanish.
		write_enable(1'b0);
		repeat (3) begin
			build_transfer(tl);
			send_transfer(tl);
		end
		drain(4);

		write_enable(1'b1);
		run_random(350);
		drain(4);

		// Last part at full rate: no idling on either side.
		write_enable(1'b1);
		src_idle_on  = 1'b0;
		sink_idle_on = 1'b0;
		run_random(250);
		drain(8);

		if (sb.failures == 0 && sb.owed.size() == 0)
			$display("usb_rx_aggregate_deframer verification clean");
		else
			$display("usb_rx_aggregate_deframer verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("usb_rx_aggregate_deframer verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
hw/rtl/urad_pkg.sv
hw/rtl/urad_parser.sv
hw/rtl/urad_out_reg.sv
hw/rtl/usb_rx_aggregate_deframer.sv
verif/usb_rx_aggregate_deframer_tb.sv
